/* rtl/u16u8_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and byte builders for the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_FOUR  = 8'hF0;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [5:0] HIGH_SURR  = 6'b110110;
  localparam logic [5:0] LOW_SURR   = 6'b110111;
  localparam logic [10:0] PLANE_OFS = 11'h040;

  // what the new unit turns into
  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_ONE,
    KIND_TWO,
    KIND_THREE,
    KIND_PAIR,
    KIND_NONE
  } kind_t;

  // one command per accepted word that makes bytes, expanded to bytes by the back end
  typedef struct packed {
    logic        prefix;  // three bytes of the held unit come first
    kind_t       kind;
    logic [15:0] hi;      // held high surrogate
    logic [20:0] val;     // code point for a pair, else the unit
  } cmd_t;

  function automatic logic [2:0] kind_len(input kind_t k);
    logic [2:0] n;
    unique case (k)
      KIND_ZERO:  n = 3'd1;
      KIND_ONE:   n = 3'd1;
      KIND_TWO:   n = 3'd2;
      KIND_THREE: n = 3'd3;
      KIND_PAIR:  n = 3'd4;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] cmd_len(input cmd_t c);
    return (c.prefix ? 3'd3 : 3'd0) + kind_len(c.kind);
  endfunction

  function automatic logic [7:0] three_byte(input logic [15:0] u, input logic [2:0] j);
    logic [7:0] b;
    unique case (j)
      3'd0:    b = LEAD_THREE | {4'b0, u[15:12]};
      3'd1:    b = CONT_MARK | {2'b0, u[11:6]};
      default: b = CONT_MARK | {2'b0, u[5:0]};
    endcase
    return b;
  endfunction

  function automatic logic [7:0] cmd_byte(input cmd_t c, input logic [2:0] idx);
    logic [2:0] plen;
    logic [2:0] j;
    logic [7:0] b;
    plen = c.prefix ? 3'd3 : 3'd0;
    j    = idx - plen;
    b    = 8'h00;
    if (idx < plen) begin
      b = three_byte(c.hi, idx);
    end else begin
      unique case (c.kind)
        KIND_ZERO:  b = 8'h00;
        KIND_ONE:   b = {1'b0, c.val[6:0]};
        KIND_TWO:   b = (j == 3'd0) ? (LEAD_TWO | {3'b0, c.val[10:6]})
                                    : (CONT_MARK | {2'b0, c.val[5:0]});
        KIND_THREE: b = three_byte(c.val[15:0], j);
        KIND_PAIR: begin
          unique case (j)
            3'd0:    b = LEAD_FOUR | {5'b0, c.val[20:18]};
            3'd1:    b = CONT_MARK | {2'b0, c.val[17:12]};
            3'd2:    b = CONT_MARK | {2'b0, c.val[11:6]};
            default: b = CONT_MARK | {2'b0, c.val[5:0]};
          endcase
        end
        default:    b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

/* rtl/u16u8_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks the held high surrogate and issues commands.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_code_unit,
  input  logic               q_full,
  output logic               q_push,
  output u16u8_pkg::cmd_t    q_cmd
);
  import u16u8_pkg::*;

  logic        held_valid_r, held_valid_nxt;
  logic [15:0] held_high_r, held_high_nxt;
  logic        is_high, is_low, pair, accept;
  logic [10:0] cp_upper;
  kind_t       kind;

  assign is_high  = (in_code_unit[15:10] == HIGH_SURR);
  assign is_low   = (in_code_unit[15:10] == LOW_SURR);
  assign pair     = held_valid_r && is_low;
  assign cp_upper = {1'b0, held_high_r[9:0]} + PLANE_OFS;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    priority if (pair)                    kind = KIND_PAIR;
    else if (in_code_unit == 16'h0000)    kind = KIND_ZERO;
    else if (in_code_unit[15:7] == 9'h0)  kind = KIND_ONE;
    else if (in_code_unit[15:11] == 5'h0) kind = KIND_TWO;
    else if (is_high)                     kind = KIND_NONE;
    else                                  kind = KIND_THREE;
  end

  always_comb begin
    q_cmd.prefix = held_valid_r && !pair;
    q_cmd.kind   = kind;
    q_cmd.hi     = held_high_r;
    q_cmd.val    = pair ? {cp_upper[10:0], in_code_unit[9:0]} : {5'b0, in_code_unit};
  end

  // a high surrogate with nothing held makes no bytes
  assign q_push = accept && (q_cmd.prefix || kind != KIND_NONE);

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_high_nxt  = held_high_r;
    if (accept) begin
      held_valid_nxt = is_high;
      held_high_nxt  = is_high ? in_code_unit : 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_high_r  <= 16'h0000;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_high_r  <= held_high_nxt;
    end
  end

endmodule

/* rtl/u16u8_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u16u8_pkg::cmd_t    push_cmd,
  input  logic               pop,
  output u16u8_pkg::cmd_t    head_cmd,
  output logic               full,
  output logic               empty
);
  import u16u8_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/u16u8_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_back
// Expands queued commands into UTF-8 bytes, one byte per cycle while out_ready holds and commands are queued.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic               clk,
  input  logic               rst_n,
  input  u16u8_pkg::cmd_t    head_cmd,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_run_last,
  output logic               out_string_end
);
  import u16u8_pkg::*;

  cmd_t       cur_r, cur_nxt;
  logic       cur_valid_r, cur_valid_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       end_r, end_nxt;
  logic       adv, is_last, take;

  assign adv     = cur_valid_r && (!out_valid_r || out_ready);
  assign is_last = (idx_r == cmd_len(cur_r) - 3'd1);
  assign take    = !cur_valid_r || (adv && is_last);
  assign q_pop   = take && !q_empty;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (q_pop) begin
      cur_nxt       = head_cmd;
      cur_valid_nxt = 1'b1;
      idx_nxt       = 3'd0;
    end else if (adv) begin
      cur_valid_nxt = !is_last;
      idx_nxt       = idx_r + 3'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    end_nxt       = end_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = cmd_byte(cur_r, idx_r);
      last_nxt      = is_last;
      // the zero byte is always the final one of its command
      end_nxt       = is_last && (cur_r.kind == KIND_ZERO);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    end_r  <= end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = byte_r;
  assign out_run_last   = last_r;
  assign out_string_end = end_r;

endmodule

/* rtl/utf16_to_utf8_encoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_unit
// UTF-16 code units in, UTF-8 bytes out, with surrogate pair joining.
//
//   channel  direction  signals
//   in       input      in_valid, in_ready, in_code_unit[15:0]
//   out      output     out_valid, out_ready, out_byte[7:0], out_run_last,
//                       out_string_end
//
// one byte leaves per cycle unless stalled: a unit makes one to three bytes,
// a surrogate pair four, a broken pair up to six; the byte serialiser sets
// this rate; the front takes a word per cycle while the queue has room
// synchronous active-low reset clears the held surrogate, queue and out_valid
// a stall on out backs up through the queue to in_ready
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_unit #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_string_end
);
  import u16u8_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic q_push, q_pop, q_full, q_empty;

  u16u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_unit (in_code_unit),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  u16u8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_cmd       (head_cmd),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule

/* sim/utf16_to_utf8_encoder_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_unit_tb
// Drives UTF-16 code units into the encoder and checks every UTF-8 byte it
// returns against a local transcoder model, byte value and both flags. The
// run covers unit length boundaries, surrogate pairs, broken and lone
// surrogates and the string terminator, then mostly well-formed random text
// under three settings of sender and receiver stalls, the last with none.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_unit_tb;

  localparam logic [5:0] TAG_HIGH = 6'b110110;
  localparam logic [5:0] TAG_LOW  = 6'b110111;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       term;
  } utf8_byte_t;

  typedef enum logic [2:0] {
    GEN_ASCII,
    GEN_TWO,
    GEN_THREE,
    GEN_PAIR,
    GEN_ZERO,
    GEN_NOISE,
    GEN_BROKEN,
    GEN_LONE_LOW
  } text_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_code_unit;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_string_end;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          fail_count;

  // local transcoder state
  logic [15:0] held_high;
  logic        held_valid;
  utf8_byte_t  step_bytes[$];
  utf8_byte_t  expected_bytes[$];

  utf16_to_utf8_encoder_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_unit   (in_code_unit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void emit(input logic [7:0] b, input logic term);
    utf8_byte_t e;
    e.data = b;
    e.last = 1'b0;
    e.term = term;
    step_bytes.push_back(e);
  endfunction

  function automatic void emit_three(input logic [15:0] u);
    emit(8'hE0 | {4'b0, u[15:12]}, 1'b0);
    emit(8'h80 | {2'b0, u[11:6]}, 1'b0);
    emit(8'h80 | {2'b0, u[5:0]}, 1'b0);
  endfunction

  // works out the bytes one accepted word gives and queues them
  function automatic void transcode_unit(input logic [15:0] u);
    logic [20:0] cp;
    utf8_byte_t  e;
    logic        paired;
    paired = 1'b0;
    step_bytes.delete();
    if (held_valid) begin
      held_valid = 1'b0;
      if (u[15:10] == TAG_LOW) begin
        paired = 1'b1;
        cp = 21'h10000 + {1'b0, held_high[9:0], u[9:0]};
        emit(8'hF0 | {5'b0, cp[20:18]}, 1'b0);
        emit(8'h80 | {2'b0, cp[17:12]}, 1'b0);
        emit(8'h80 | {2'b0, cp[11:6]}, 1'b0);
        emit(8'h80 | {2'b0, cp[5:0]}, 1'b0);
      end else begin
        emit_three(held_high);
      end
      held_high = 16'h0000;
    end
    if (!paired) begin
      if (u == 16'h0000) begin
        emit(8'h00, 1'b1);
      end else if (u[15:7] == 9'd0) begin
        emit({1'b0, u[6:0]}, 1'b0);
      end else if (u[15:11] == 5'd0) begin
        emit(8'hC0 | {3'b0, u[10:6]}, 1'b0);
        emit(8'h80 | {2'b0, u[5:0]}, 1'b0);
      end else if (u[15:10] == TAG_HIGH) begin
        held_high  = u;
        held_valid = 1'b1;
      end else begin
        emit_three(u);
      end
    end
    foreach (step_bytes[i]) begin
      e = step_bytes[i];
      if (i == step_bytes.size() - 1) e.last = 1'b1;
      expected_bytes.push_back(e);
    end
  endfunction

  task automatic send_unit(input logic [15:0] u);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_code_unit = u;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    transcode_unit(u);
  endtask

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : check_bytes
    utf8_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %0h", $time, out_byte);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data) report("out_byte", want.data, out_byte);
        if (out_run_last !== want.last) report("out_run_last", want.last, out_run_last);
        if (out_string_end !== want.term) report("out_string_end", want.term, out_string_end);
      end
    end
  end

  task automatic test_unit_lengths();
    send_unit(16'h0001);
    send_unit(16'h007F);
    send_unit(16'h0080);
    send_unit(16'h07FF);
    send_unit(16'h0800);
    send_unit(16'hD7FF);
    send_unit(16'hE000);
    send_unit(16'hFFFF);
  endtask

  task automatic test_surrogate_pairs();
    send_unit(16'hD800);
    send_unit(16'hDC00);
    send_unit(16'hDBFF);
    send_unit(16'hDFFF);
  endtask

  task automatic test_broken_pairs();
    // lone low, high then plain text, high after high, high before terminator
    send_unit(16'hDC00);
    send_unit(16'hD800);
    send_unit(16'h0041);
    send_unit(16'hDBFF);
    send_unit(16'hD800);
    send_unit(16'hDFFF);
    send_unit(16'hD812);
    send_unit(16'h0000);
  endtask

  task automatic test_string_end();
    send_unit(16'h0000);
    send_unit(16'h0000);
  endtask

  task automatic test_random_text(input int n_units);
    int         sent;
    int unsigned pick;
    text_kind_t kind;
    logic [15:0] u;
    sent = 0;
    while (sent < n_units) begin
      pick = $urandom_range(99);
      if (pick < 25)      kind = GEN_ASCII;
      else if (pick < 40) kind = GEN_TWO;
      else if (pick < 60) kind = GEN_THREE;
      else if (pick < 80) kind = GEN_PAIR;
      else if (pick < 85) kind = GEN_ZERO;
      else if (pick < 92) kind = GEN_NOISE;
      else if (pick < 97) kind = GEN_BROKEN;
      else                kind = GEN_LONE_LOW;
      case (kind)
        GEN_ASCII: begin
          send_unit(16'($urandom_range(16'h0001, 16'h007F)));
          sent += 1;
        end
        GEN_TWO: begin
          send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
          sent += 1;
        end
        GEN_THREE: begin
          u = 16'($urandom_range(16'h0800, 16'hFFFF));
          // push surrogates up into the F800 to FFFF range
          if (u[15:11] == 5'b11011) u = u ^ 16'h2000;
          send_unit(u);
          sent += 1;
        end
        GEN_PAIR: begin
          send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
          send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
          sent += 2;
        end
        GEN_ZERO: begin
          send_unit(16'h0000);
          sent += 1;
        end
        GEN_NOISE: begin
          send_unit(16'($urandom_range(16'hFFFF)));
          sent += 1;
        end
        GEN_BROKEN: begin
          send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
          send_unit(16'($urandom_range(16'hFFFF)));
          sent += 2;
        end
        default: begin
          send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
          sent += 1;
        end
      endcase
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_code_unit  = 16'h0000;
    out_ready     = 1'b0;
    held_high     = 16'h0000;
    held_valid    = 1'b0;
    fail_count    = 0;
    send_idle_pct = 27;
    recv_idle_pct = 81;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_unit_lengths();
    test_surrogate_pairs();
    test_broken_pairs();
    test_string_end();
    test_random_text(152);

    send_idle_pct = 81;
    recv_idle_pct = 27;
    test_random_text(152);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_text(152);

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout with %0d bytes outstanding", $time, expected_bytes.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* utf16_to_utf8_encoder_unit.f */
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_encoder_unit.sv
sim/utf16_to_utf8_encoder_unit_tb.sv
